>>> sv/ccd_pkg.sv
// shared types and constants of the contact change detector
package ccd_pkg;

  localparam int BusCountDefault       = 8;
  localparam int ContactsPerBusDefault = 4096;

  // result kinds
  localparam logic [1:0] KIND_CHANGE = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_NODATA = 2'd2;

  // configuration register select (paddr bit 2)
  localparam logic REG_WIDE = 1'b0;
  localparam logic REG_LSB  = 1'b1;

  // one contact table entry
  typedef struct packed {
    logic        known;
    logic        value;
    logic [31:0] stamp;
  } ccd_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_step;
    logic scan_issue;
    logic flush;
    logic q_read;
    logic q_answer;
  } ccd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic upd_ok;
    logic scan_last;
  } ccd_stat_t;

endpackage

>>> sv/contact_change_detector.sv
// top level of the contact change detector: register port, controller, datapath
//
// the block keeps value, known flag and time stamp for BUS_COUNT x
// CONTACTS_PER_BUS feedback contacts in a single-port-read table memory.
// after reset a clearing pass writes every table entry, one per cycle, and
// busy stays high until it is through; register writes are taken during
// that time. a word is accepted when start is high and busy is low. a module
// update reads one contact per cycle from the table and compares it in the
// next, then drains the last compare and flushes the held change; an ignored
// update (bad bus, module zero) goes back to idle after its start state, and
// a query reads the table once and then answers.
// results come out on out_strobe for exactly one cycle each and cannot be
// held off; the last word of an update's run carries out_last_of_run and
// appears no later than the cycle in which busy drops. an update with no
// changed contacts gives no result words.
module contact_change_detector
  import ccd_pkg::*;
#(
  parameter int BUS_COUNT        = BusCountDefault,
  parameter int CONTACTS_PER_BUS = ContactsPerBusDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [2:0]  in_bus_index,
  input  logic [9:0]  in_module_number,
  input  logic [15:0] in_contact_bits,
  input  logic [12:0] in_query_contact,
  input  logic [31:0] in_now_time,
  // result channel
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_event_bus,
  output logic [12:0] out_event_contact,
  output logic        out_contact_value,
  output logic [31:0] out_event_time,
  output logic        out_last_of_run,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // per-bus width and bit order registers
  logic [7:0] wide_r, wide_nxt;
  logic [7:0] lsb_r, lsb_nxt;
  logic       cfg_wr;

  ccd_cmd_t  cmd;
  ccd_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // register write decode, word select by address bit 2
  always_comb begin
    wide_nxt = wide_r;
    lsb_nxt  = lsb_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDE: wide_nxt = pwdata[7:0];
        REG_LSB:  lsb_nxt  = pwdata[7:0];
        default:  wide_nxt = wide_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 8'd0;
      lsb_r  <= 8'd0;
    end else begin
      wide_r <= wide_nxt;
      lsb_r  <= lsb_nxt;
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[2])
      REG_WIDE: prdata = {24'd0, wide_r};
      REG_LSB:  prdata = {24'd0, lsb_r};
      default:  prdata = 32'd0;
    endcase
  end

  // sequencing: clear pass, then one word at a time
  ccd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // table, scan pipeline and result register
  ccd_datapath #(
    .BUS_COUNT        (BUS_COUNT),
    .CONTACTS_PER_BUS (CONTACTS_PER_BUS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .wide_cfg          (wide_r),
    .lsb_cfg           (lsb_r),
    .in_mode           (in_mode),
    .in_bus_index      (in_bus_index),
    .in_module_number  (in_module_number),
    .in_contact_bits   (in_contact_bits),
    .in_query_contact  (in_query_contact),
    .in_now_time       (in_now_time),
    .out_strobe        (out_strobe),
    .out_result_kind   (out_result_kind),
    .out_event_bus     (out_event_bus),
    .out_event_contact (out_event_contact),
    .out_contact_value (out_contact_value),
    .out_event_time    (out_event_time),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

>>> sv/ccd_table.sv
// contact table memory, one write port and one registered read port
module ccd_table
  import ccd_pkg::*;
#(
  parameter int DEPTH = BusCountDefault * ContactsPerBusDefault
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  ccd_entry_t               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output ccd_entry_t               rd_data
);

  ccd_entry_t mem [DEPTH];
  ccd_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/ccd_ctrl.sv
// sequencing state machine of the contact change detector
module ccd_ctrl
  import ccd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ccd_stat_t stat,
  output ccd_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_SCAN,
    S_DRAIN,
    S_FINAL,
    S_QREAD,
    S_QANS
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.is_query) begin
          state_nxt = S_QREAD;
        end else if (stat.upd_ok) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QREAD: begin
        cmd.q_read = 1'b1;
        state_nxt  = S_QANS;
      end
      S_QANS: begin
        cmd.q_answer = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> sv/ccd_datapath.sv
// item registers, contact scan pipeline, table access and result register
module ccd_datapath
  import ccd_pkg::*;
#(
  parameter int BUS_COUNT        = BusCountDefault,
  parameter int CONTACTS_PER_BUS = ContactsPerBusDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ccd_cmd_t    cmd,
  output ccd_stat_t   stat,
  input  logic [7:0]  wide_cfg,
  input  logic [7:0]  lsb_cfg,
  input  logic        in_mode,
  input  logic [2:0]  in_bus_index,
  input  logic [9:0]  in_module_number,
  input  logic [15:0] in_contact_bits,
  input  logic [12:0] in_query_contact,
  input  logic [31:0] in_now_time,
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [2:0]  out_event_bus,
  output logic [12:0] out_event_contact,
  output logic        out_contact_value,
  output logic [31:0] out_event_time,
  output logic        out_last_of_run
);

  localparam int DEPTH  = BUS_COUNT * CONTACTS_PER_BUS;
  localparam int ADDR_W = $clog2(DEPTH);

  // latched item
  logic        mode_r;
  logic [2:0]  bus_r;
  logic [9:0]  module_r;
  logic [15:0] bits_r;
  logic [12:0] query_r;
  logic [31:0] now_r;
  logic        wide_r;
  logic        lsb_r;

  // counters
  logic [ADDR_W-1:0] clr_r;
  logic [3:0]        idx_r;

  // compare stage
  logic              p_valid_r;
  logic [ADDR_W-1:0] p_addr_r;
  logic              p_val_r;
  logic [12:0]       p_contact_r;

  // pending change, held until the next one shows whether it is the last
  logic        hold_valid_r, hold_valid_nxt;
  logic [12:0] hold_contact_r, hold_contact_nxt;
  logic        hold_value_r, hold_value_nxt;

  // result register
  logic        strobe_r, strobe_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  obus_r, obus_nxt;
  logic [12:0] ocontact_r, ocontact_nxt;
  logic        ovalue_r, ovalue_nxt;
  logic [31:0] otime_r, otime_nxt;
  logic        olast_r, olast_nxt;

  // address generation
  logic              bus_ok;
  logic              q_ok;
  logic [3:0]        ports_m1;
  logic [3:0]        pos;
  logic              bit_val;
  logic [9:0]        mod_m1;
  logic [13:0]       first;
  logic [13:0]       contact;
  logic              in_table;
  logic [31:0]       bus_base;
  logic [31:0]       scan_full;
  logic [31:0]       q_full;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;
  ccd_entry_t        wr_data;
  ccd_entry_t        rd_data;
  logic              changed;

  assign bus_ok   = (32'(bus_r) < 32'(BUS_COUNT));
  assign q_ok     = bus_ok && (query_r != 13'd0) &&
                    (32'(query_r) <= 32'(CONTACTS_PER_BUS));
  assign ports_m1 = wide_r ? 4'd15 : 4'd7;
  assign pos      = lsb_r ? idx_r : (ports_m1 - idx_r);
  assign bit_val  = bits_r[pos];
  assign mod_m1   = module_r - 10'd1;
  assign first    = wide_r ? {mod_m1, 4'b0000} : {1'b0, mod_m1, 3'b000};
  assign contact  = first + {10'b0, idx_r};
  assign in_table = (32'(contact) < 32'(CONTACTS_PER_BUS));
  assign bus_base = 32'(bus_r) * 32'(CONTACTS_PER_BUS);
  assign scan_full = bus_base + 32'(contact);
  assign q_full    = bus_base + 32'(query_r) - 32'd1;
  assign rd_addr   = cmd.q_read ? q_full[ADDR_W-1:0] : scan_full[ADDR_W-1:0];

  assign stat.clear_last = (clr_r == ADDR_W'(DEPTH - 1));
  assign stat.is_query   = mode_r;
  assign stat.upd_ok     = bus_ok && (module_r != 10'd0);
  assign stat.scan_last  = (idx_r == ports_m1);

  assign changed = p_valid_r && (!rd_data.known || (rd_data.value != p_val_r));

  assign wr_en   = cmd.clear_step || changed;
  assign wr_addr = cmd.clear_step ? clr_r : p_addr_r;
  always_comb begin
    if (cmd.clear_step) begin
      wr_data = '0;
    end else begin
      wr_data.known = 1'b1;
      wr_data.value = p_val_r;
      wr_data.stamp = now_r;
    end
  end

  ccd_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    hold_valid_nxt   = hold_valid_r;
    hold_contact_nxt = hold_contact_r;
    hold_value_nxt   = hold_value_r;
    strobe_nxt       = 1'b0;
    kind_nxt         = kind_r;
    obus_nxt         = obus_r;
    ocontact_nxt     = ocontact_r;
    ovalue_nxt       = ovalue_r;
    otime_nxt        = otime_r;
    olast_nxt        = olast_r;
    if (cmd.q_answer) begin
      strobe_nxt   = 1'b1;
      obus_nxt     = bus_r;
      ocontact_nxt = query_r;
      olast_nxt    = 1'b1;
      if (q_ok && rd_data.known) begin
        kind_nxt   = KIND_DATA;
        ovalue_nxt = rd_data.value;
        otime_nxt  = rd_data.stamp;
      end else begin
        kind_nxt   = KIND_NODATA;
        ovalue_nxt = 1'b0;
        otime_nxt  = 32'd0;
      end
    end else if (hold_valid_r && (changed || cmd.flush)) begin
      strobe_nxt   = 1'b1;
      kind_nxt     = KIND_CHANGE;
      obus_nxt     = bus_r;
      ocontact_nxt = hold_contact_r;
      ovalue_nxt   = hold_value_r;
      otime_nxt    = now_r;
      olast_nxt    = cmd.flush;
    end
    if (changed) begin
      hold_valid_nxt   = 1'b1;
      hold_contact_nxt = p_contact_r;
      hold_value_nxt   = p_val_r;
    end else if (cmd.flush) begin
      hold_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r        <= '0;
      idx_r        <= '0;
      p_valid_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.scan_issue) begin
        idx_r <= idx_r + 4'd1;
      end
      p_valid_r    <= cmd.scan_issue && in_table;
      hold_valid_r <= hold_valid_nxt;
      strobe_r     <= strobe_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      bus_r    <= in_bus_index;
      module_r <= in_module_number;
      bits_r   <= in_contact_bits;
      query_r  <= in_query_contact;
      now_r    <= in_now_time;
      wide_r   <= wide_cfg[in_bus_index];
      lsb_r    <= lsb_cfg[in_bus_index];
    end
    p_addr_r       <= scan_full[ADDR_W-1:0];
    p_val_r        <= bit_val;
    p_contact_r    <= 13'(contact + 14'd1);
    hold_contact_r <= hold_contact_nxt;
    hold_value_r   <= hold_value_nxt;
    kind_r         <= kind_nxt;
    obus_r         <= obus_nxt;
    ocontact_r     <= ocontact_nxt;
    ovalue_r       <= ovalue_nxt;
    otime_r        <= otime_nxt;
    olast_r        <= olast_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_result_kind   = kind_r;
  assign out_event_bus     = obus_r;
  assign out_event_contact = ocontact_r;
  assign out_contact_value = ovalue_r;
  assign out_event_time    = otime_r;
  assign out_last_of_run   = olast_r;

endmodule

>>> bench/ccd_checker.sv
`timescale 1ns / 100ps
// word modes shared by the bench, and the checker that predicts and compares result words
package ccd_tb_pkg;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

endpackage

module ccd_checker
  import ccd_pkg::*;
  import ccd_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_mode,
  input  logic [2:0]  in_bus_index,
  input  logic [9:0]  in_module_number,
  input  logic [15:0] in_contact_bits,
  input  logic [12:0] in_query_contact,
  input  logic [31:0] in_now_time,
  input  logic        out_strobe,
  input  logic [1:0]  out_result_kind,
  input  logic [2:0]  out_event_bus,
  input  logic [12:0] out_event_contact,
  input  logic        out_contact_value,
  input  logic [31:0] out_event_time,
  input  logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          awaited_count
);

  localparam int Buses    = BusCountDefault;
  localparam int Contacts = ContactsPerBusDefault;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  bus;
    logic [12:0] contact;
    logic        value;
    logic [31:0] stamp;
    logic        last;
  } contact_word_t;

  // own copy of the contact table and the per-bus layout registers
  logic        seen      [Buses*Contacts];
  logic        level     [Buses*Contacts];
  logic [31:0] stamp_tbl [Buses*Contacts];
  logic [7:0]  wide_map;
  logic [7:0]  lsb_map;

  contact_word_t awaited[$];

  task automatic predict_word(input logic mode, input logic [2:0] bus,
                              input logic [9:0] module_no, input logic [15:0] bits,
                              input logic [12:0] query, input logic [31:0] now);
    int            ports;
    int            first;
    int            pos;
    int            c;
    int            idx;
    logic          lsb_order;
    logic          val;
    contact_word_t w;
    contact_word_t held;
    bit            have_held;
    have_held = 1'b0;
    if (mode == MODE_QUERY) begin
      w.kind    = KIND_NODATA;
      w.bus     = bus;
      w.contact = query;
      w.value   = 1'b0;
      w.stamp   = '0;
      w.last    = 1'b1;
      if (int'(bus) < Buses && query >= 1 && int'(query) <= Contacts) begin
        idx = int'(bus) * Contacts + int'(query) - 1;
        if (seen[idx]) begin
          w.kind  = KIND_DATA;
          w.value = level[idx];
          w.stamp = stamp_tbl[idx];
        end
      end
      awaited.push_back(w);
    end else if (int'(bus) < Buses && module_no != 0) begin
      ports     = wide_map[bus] ? 16 : 8;
      lsb_order = lsb_map[bus];
      first     = (int'(module_no) - 1) * ports;
      for (int i = 0; i < ports; i++) begin
        pos = lsb_order ? i : ports - 1 - i;
        val = bits[pos];
        c   = first + i;
        if (c >= Contacts) continue;
        idx = int'(bus) * Contacts + c;
        if (!seen[idx] || level[idx] != val) begin
          seen[idx]      = 1'b1;
          level[idx]     = val;
          stamp_tbl[idx] = now;
          if (have_held) awaited.push_back(held);
          held.kind    = KIND_CHANGE;
          held.bus     = bus;
          held.contact = 13'(c + 1);
          held.value   = val;
          held.stamp   = now;
          held.last    = 1'b0;
          have_held    = 1'b1;
        end
      end
      // the final change of the run carries the last flag
      if (have_held) begin
        held.last = 1'b1;
        awaited.push_back(held);
      end
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    contact_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < Buses * Contacts; i++) begin
        seen[i]      = 1'b0;
        level[i]     = 1'b0;
        stamp_tbl[i] = '0;
      end
      wide_map   = '0;
      lsb_map    = '0;
      mismatches = 0;
      awaited.delete();
    end else begin
      if (out_strobe) begin
        if (awaited.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, got kind %0d bus %0d contact %0d",
                   $time, out_result_kind, out_event_bus, out_event_contact);
        end else begin
          want = awaited.pop_front();
          compare_field("result_kind", 32'(want.kind), 32'(out_result_kind));
          compare_field("event_bus", 32'(want.bus), 32'(out_event_bus));
          compare_field("event_contact", 32'(want.contact), 32'(out_event_contact));
          compare_field("contact_value", 32'(want.value), 32'(out_contact_value));
          compare_field("event_time", want.stamp, out_event_time);
          compare_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_LSB) lsb_map = pwdata[7:0];
        else wide_map = pwdata[7:0];
      end
      if (start && !busy) begin
        predict_word(in_mode, in_bus_index, in_module_number, in_contact_bits,
                     in_query_contact, in_now_time);
      end
    end
    awaited_count = awaited.size();
  end

endmodule

>>> bench/tb_contact_change_detector.sv
`timescale 1ns / 100ps
// stimulus and verdict for the contact change detector
module tb_contact_change_detector;
  import ccd_pkg::*;
  import ccd_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_mode;
  logic [2:0]  in_bus_index;
  logic [9:0]  in_module_number;
  logic [15:0] in_contact_bits;
  logic [12:0] in_query_contact;
  logic [31:0] in_now_time;
  logic        out_strobe;
  logic [1:0]  out_result_kind;
  logic [2:0]  out_event_bus;
  logic [12:0] out_event_contact;
  logic        out_contact_value;
  logic [31:0] out_event_time;
  logic        out_last_of_run;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int awaited_count;

  // last contact word sent per bus for modules 1..8, so that updates
  // revisit known contacts and change only a few of them
  logic [15:0] recent_word [8][8];
  // words still to be sent back to back with no idle cycle
  int          burst_left;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  contact_change_detector dut (.*);

  ccd_checker u_checker (.*);

  // run limit, set with a wide margin over the clearing pass after reset
  // and the whole stimulus
  initial begin
    #2_000_000;
    $display("** contact_change_detector: FAILED **");
    $finish;
  end

  // register write: setup cycle then access cycle, taken when pready is high
  task automatic write_reg(input logic sel, input logic [7:0] val);
    logic [31:0] noise;
    noise = $urandom;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    // upper data bits carry junk, only the low byte belongs to the register
    pwdata  = {noise[31:8], val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // present one command word and hold it until the block takes it,
  // then idle for a random gap unless inside a back-to-back burst
  task automatic issue_word(input logic mode, input logic [2:0] bus,
                            input logic [9:0] module_no, input logic [15:0] bits,
                            input logic [12:0] query, input logic [31:0] now);
    int pick;
    int gap;
    @(negedge clk);
    in_mode          = mode;
    in_bus_index     = bus;
    in_module_number = module_no;
    in_contact_bits  = bits;
    in_query_contact = query;
    in_now_time      = now;
    start            = 1'b1;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4) burst_left = $urandom_range(8, 16);
      // mostly short gaps, a few long ones
      if (pick < 45) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // stop sending and wait until every predicted result word has come and
  // the block is idle, so that an update with no changes also runs out
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    for (int n = 0; n < 5000 && (awaited_count != 0 || busy); n++) @(negedge clk);
    repeat (24) @(negedge clk);
  endtask

  // one random command word; counted is low for words the block ignores
  task automatic random_word(output bit counted);
    int          pick;
    logic [2:0]  bus;
    logic [9:0]  module_no;
    logic [15:0] bits;
    logic [12:0] query;
    logic [31:0] now;
    pick      = $urandom_range(0, 99);
    bus       = 3'($urandom);
    module_no = 10'($urandom);
    bits      = 16'($urandom);
    query     = 13'($urandom);
    now       = $urandom;
    counted   = 1'b1;
    if (pick < 22) begin
      // queries mostly aim at the contacts that updates keep touching,
      // the rest cover the whole 13-bit field, zero and beyond the table
      if (pick < 16) query = 13'($urandom_range(1, 136));
      issue_word(MODE_QUERY, bus, module_no, bits, query, now);
    end else if (pick < 28) begin
      // noise updates: module zero, or any module number up to the top
      // of the field, most of them beyond the table
      if (pick < 24) module_no = '0;
      counted = (module_no != 0);
      issue_word(MODE_UPDATE, bus, module_no, bits, query, now);
    end else begin
      // well-formed update of a low module: fresh word, repeated word
      // (no changes) or a single flipped contact
      module_no = 10'($urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0: begin
          bits = 16'($urandom);
        end
        1: begin
          bits = recent_word[bus][module_no - 1];
        end
        default: begin
          bits = recent_word[bus][module_no - 1] ^ (16'h1 << $urandom_range(0, 15));
        end
      endcase
      recent_word[bus][module_no - 1] = bits;
      issue_word(MODE_UPDATE, bus, module_no, bits, query, now);
    end
  endtask

  initial begin
    logic [7:0] wide_set [6];
    logic [7:0] lsb_set  [6];
    bit         counted;
    int         made;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_mode          = MODE_UPDATE;
    in_bus_index     = '0;
    in_module_number = '0;
    in_contact_bits  = '0;
    in_query_contact = '0;
    in_now_time      = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    burst_left       = 0;
    for (int b = 0; b < 8; b++) begin
      for (int m = 0; m < 8; m++) recent_word[b][m] = '0;
    end

    // register settings per phase: all narrow msb-first, all wide
    // lsb-first, mixed extremes and two random mixes
    wide_set[0] = 8'h00;  lsb_set[0] = 8'h00;
    wide_set[1] = 8'hFF;  lsb_set[1] = 8'hFF;
    wide_set[2] = 8'($urandom); lsb_set[2] = 8'($urandom);
    wide_set[3] = 8'hFF;  lsb_set[3] = 8'h00;
    wide_set[4] = 8'h00;  lsb_set[4] = 8'hFF;
    wide_set[5] = 8'($urandom); lsb_set[5] = 8'($urandom);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) settle();
      write_reg(REG_WIDE, wide_set[phase]);
      write_reg(REG_LSB, lsb_set[phase]);
      // the first phase also waits out the clearing pass after reset
      @(negedge clk);
      while (busy) @(negedge clk);

      if (phase == 0) begin
        // narrow modules, top bit first
        // query before any data
        issue_word(MODE_QUERY, 3'd0, 10'd0, 16'h0000, 13'd1, 32'd7);
        // first update: every contact unknown, all eight report
        issue_word(MODE_UPDATE, 3'd0, 10'd1, 16'h00A5, 13'd0, 32'd0);
        // same word again: nothing changed
        issue_word(MODE_UPDATE, 3'd0, 10'd1, 16'h00A5, 13'd0, 32'd5);
        // one contact flips, upper byte ignored on a narrow module
        issue_word(MODE_UPDATE, 3'd0, 10'd1, 16'hFFA4, 13'd0, 32'hFFFF_FFFF);
        issue_word(MODE_QUERY, 3'd0, 10'd0, 16'h0000, 13'd8, 32'd0);
        issue_word(MODE_QUERY, 3'd0, 10'd0, 16'h0000, 13'd1, 32'd0);
        // contact zero, last contact never written, contacts beyond table
        issue_word(MODE_QUERY, 3'd0, 10'd0, 16'h0000, 13'd0, 32'd0);
        issue_word(MODE_QUERY, 3'd0, 10'd0, 16'h0000, 13'd4096, 32'd0);
        issue_word(MODE_QUERY, 3'd0, 10'd0, 16'h0000, 13'd4097, 32'd0);
        issue_word(MODE_QUERY, 3'd7, 10'd1023, 16'hFFFF, 13'd8191, 32'hFFFF_FFFF);
        // module zero is dropped
        issue_word(MODE_UPDATE, 3'd3, 10'd0, 16'hFFFF, 13'd0, 32'd9);
        // last module of the table on the last bus
        issue_word(MODE_UPDATE, 3'd7, 10'd512, 16'h00FF, 13'd0, 32'h8000_0000);
        issue_word(MODE_QUERY, 3'd7, 10'd0, 16'h0000, 13'd4096, 32'd0);
        // modules wholly beyond the table
        issue_word(MODE_UPDATE, 3'd3, 10'd1023, 16'hFFFF, 13'd0, 32'd11);
        issue_word(MODE_UPDATE, 3'd2, 10'd513, 16'hFFFF, 13'd0, 32'd12);
      end else if (phase == 1) begin
        // wide modules, bit 0 first
        issue_word(MODE_UPDATE, 3'd5, 10'd256, 16'h8001, 13'd0, 32'd100);
        issue_word(MODE_UPDATE, 3'd5, 10'd256, 16'h0001, 13'd0, 32'd200);
        issue_word(MODE_UPDATE, 3'd5, 10'd257, 16'hFFFF, 13'd0, 32'd300);
        issue_word(MODE_QUERY, 3'd5, 10'd0, 16'h0000, 13'd4096, 32'd0);
        issue_word(MODE_QUERY, 3'd5, 10'd0, 16'h0000, 13'd4081, 32'd0);
        // bus 0 now wide: the first eight contacts are known, the rest new
        issue_word(MODE_UPDATE, 3'd0, 10'd1, 16'h5A5A, 13'd0, 32'd400);
        issue_word(MODE_QUERY, 3'd0, 10'd0, 16'h0000, 13'd16, 32'd0);
      end

      made = 0;
      while (made < 23) begin
        random_word(counted);
        if (counted) made++;
        // now and then hold off until every result word is in
        if ($urandom_range(0, 19) == 0) settle();
      end
    end

    settle();
    repeat (30) @(negedge clk);
    if (mismatches == 0 && awaited_count == 0) begin
      $display("** contact_change_detector: PASSED **");
    end else begin
      if (awaited_count != 0) $display("%0d result words never arrived", awaited_count);
      $display("** contact_change_detector: FAILED **");
    end
    $finish;
  end

endmodule

>>> contact_change_detector.f
sv/ccd_pkg.sv
sv/ccd_table.sv
sv/ccd_ctrl.sv
sv/ccd_datapath.sv
sv/contact_change_detector.sv
bench/ccd_checker.sv
bench/tb_contact_change_detector.sv
